/* rtl/iidl_pkg.sv */
// Shared widths, opcodes, status codes and control types for the indexed list.
package iidl_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int DATA_W       = 32;
   localparam int OPCODE_W     = 3;
   localparam int POS_W        = 7;
   localparam int STATUS_W     = 2;
   localparam int LEN_W        = 7;
   localparam int READ_GROUP   = 8;

   localparam logic [OPCODE_W-1:0] OP_READ   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_FRONT  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic ins;
      logic del;
   } shift_ctl_type;

endpackage

/* rtl/iidl_if.sv */
// Request and response channel interfaces for the indexed list.
interface iidl_req_if;
   import iidl_pkg::*;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [POS_W-1:0]    position;
   logic [DATA_W-1:0]   value;
   modport source (output valid, output opcode, output position, output value, input ready);
   modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface iidl_rsp_if;
   import iidl_pkg::*;
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   read_value;
   logic [STATUS_W-1:0] status;
   logic [LEN_W-1:0]    length;
   modport source (output valid, output read_value, output status, output length, input ready);
   modport sink   (input valid, input read_value, input status, input length, output ready);
endinterface

/* rtl/indexed_insert_delete_list.sv */
// Indexed list of signed words held in a row of shifting cells.
// A result passes the s1 registers, the read-tree group registers and the output register.
// No new item is accepted while one is in s1 or s2; a receiver stall keeps it in s2.
// Inserts and deletes shift all cells at or after the position at once in the accept cycle.
// Reset (synchronous) empties the list and clears all valid flags; cell contents stay as they are.
module indexed_insert_delete_list #(
   parameter int CAPACITY = iidl_pkg::CAPACITY_DEF
) (
   input logic      clock,
   input logic      reset,
   iidl_req_if.sink   req,
   iidl_rsp_if.source rsp
);
   import iidl_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic [CNT_W-1:0]    rd_pos_ff;
   logic                rd_hit_ff;
   logic [DATA_W-1:0]   rd_fixed_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [LEN_W-1:0]    len_ff;
   logic [DATA_W-1:0]   out_read_value_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [LEN_W-1:0]    out_length_ff;

   logic                accept, move_out;
   logic [CMP_W-1:0]    pos_ext, count_ext, ins_pos;
   logic                is_ins, do_ins, do_del, rd_ok;
   logic [DATA_W-1:0]   rd_fixed_in;
   shift_ctl_type       ctl;
   logic [CNT_W-1:0]    cell_pos;
   logic [DATA_W-1:0]   tree_result;

   logic [CAPACITY-1:0][DATA_W-1:0] cell_values;
   logic [CAPACITY-1:0][DATA_W-1:0] hit_values;

   assign req.ready = !s1_valid_ff && !s2_valid_ff;
   assign accept    = req.valid && req.ready;
   assign move_out  = s2_valid_ff && (!out_valid_ff || rsp.ready);

   assign pos_ext   = CMP_W'(req.position);
   assign count_ext = CMP_W'(count_ff);

   always_comb begin
      ins_pos     = pos_ext;
      is_ins      = 1'b0;
      do_ins      = 1'b0;
      do_del      = 1'b0;
      rd_ok       = 1'b0;
      rd_fixed_in = '0;
      status_in   = ST_DONE;
      case (req.opcode)
         OP_READ: begin
            if (pos_ext < count_ext) begin
               rd_ok = 1'b1;
            end else begin
               rd_fixed_in = '1;
               status_in   = ST_RANGE;
            end
         end
         OP_FRONT: begin
            is_ins  = 1'b1;
            ins_pos = '0;
         end
         OP_APPEND: begin
            is_ins  = 1'b1;
            ins_pos = count_ext;
         end
         OP_INSERT: begin
            is_ins = 1'b1;
         end
         OP_DELETE: begin
            if (pos_ext < count_ext) begin
               do_del = 1'b1;
            end else begin
               status_in = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
      if (is_ins) begin
         // range check takes precedence over full
         if (ins_pos > count_ext) begin
            status_in = ST_RANGE;
         end else if (count_ext >= CMP_W'(CAPACITY)) begin
            status_in = ST_FULL;
         end else begin
            do_ins = 1'b1;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_del) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign ctl.ins  = accept && do_ins;
   assign ctl.del  = accept && do_del;
   assign cell_pos = CNT_W'(ins_pos);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_value, right_value;
      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_left
         assign left_value = cell_values[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_right
         assign right_value = cell_values[i+1];
      end
      iidl_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock          (clock),
         .ctl            (ctl),
         .pos            (cell_pos),
         .ins_value      (req.value),
         .left_value     (left_value),
         .right_value    (right_value),
         .read_pos       (rd_pos_ff),
         .value          (cell_values[i]),
         .read_hit_value (hit_values[i])
      );
   end

   iidl_read_tree #(
      .CAPACITY (CAPACITY)
   ) u_read_tree (
      .clock      (clock),
      .hit_values (hit_values),
      .result     (tree_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         s1_valid_ff <= accept;
         if (s1_valid_ff) begin
            s2_valid_ff <= 1'b1;
         end else if (move_out) begin
            s2_valid_ff <= 1'b0;
         end
         if (move_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_pos_ff   <= CNT_W'(pos_ext);
         rd_hit_ff   <= rd_ok;
         rd_fixed_ff <= rd_fixed_in;
         status_ff   <= status_in;
         len_ff      <= LEN_W'(count_in);
      end
      if (move_out) begin
         out_read_value_ff <= rd_hit_ff ? tree_result : rd_fixed_ff;
         out_status_ff     <= status_ff;
         out_length_ff     <= len_ff;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.read_value = out_read_value_ff;
   assign rsp.status     = out_status_ff;
   assign rsp.length     = out_length_ff;

`ifndef ASSERT_OFF
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && s2_valid_ff))
      else $error("two items in the read stages at once");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item did not enter the first stage");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff == ST_FULL |-> out_length_ff == LEN_W'(CAPACITY))
      else $error("full status with length other than capacity");
`endif

endmodule

/* rtl/iidl_cell.sv */
// One list slot: holds an entry and shifts to or from its neighbours on insert and delete.
module iidl_cell #(
   parameter int CNT_W = 7,
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  iidl_pkg::shift_ctl_type   ctl,
   input  logic [CNT_W-1:0]          pos,
   input  logic [iidl_pkg::DATA_W-1:0] ins_value,
   input  logic [iidl_pkg::DATA_W-1:0] left_value,
   input  logic [iidl_pkg::DATA_W-1:0] right_value,
   input  logic [CNT_W-1:0]          read_pos,
   output logic [iidl_pkg::DATA_W-1:0] value,
   output logic [iidl_pkg::DATA_W-1:0] read_hit_value
);
   import iidl_pkg::*;

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.ins) begin
         if (MY_INDEX > pos) begin
            value_in = left_value;
         end else if (MY_INDEX == pos) begin
            value_in = ins_value;
         end
      end else if (ctl.del && MY_INDEX >= pos) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value          = value_ff;
   assign read_hit_value = (read_pos == MY_INDEX) ? value_ff : '0;

endmodule

/* rtl/iidl_read_tree.sv */
// Two-level OR tree that collects the one selected cell value for a read.
module iidl_read_tree #(
   parameter int CAPACITY = iidl_pkg::CAPACITY_DEF
) (
   input  logic                                  clock,
   input  logic [CAPACITY-1:0][iidl_pkg::DATA_W-1:0] hit_values,
   output logic [iidl_pkg::DATA_W-1:0]           result
);
   import iidl_pkg::*;

   localparam int NUM_GROUPS = (CAPACITY + READ_GROUP - 1) / READ_GROUP;

   logic [NUM_GROUPS-1:0][DATA_W-1:0] group_ff;
   logic [NUM_GROUPS-1:0][DATA_W-1:0] group_in;

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < READ_GROUP; k++) begin
            if (g * READ_GROUP + k < CAPACITY) begin
               group_in[g] = group_in[g] | hit_values[g * READ_GROUP + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   always_comb begin
      result = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         result = result | group_ff[g];
      end
   end

endmodule

/* bench/list_tracker_pkg.sv */
// Scoreboard class that tracks the expected contents of the indexed list and checks results.
package list_tracker_pkg;
   import iidl_pkg::*;

   typedef struct {
      logic [DATA_W-1:0]   read_value;
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    length;
   } list_answer_type;

   class list_tracker;
      logic [DATA_W-1:0] slots [CAPACITY_DEF];
      int unsigned       fill;
      list_answer_type   pending_answers [$];
      int unsigned       failures;

      function new();
         fill     = 0;
         failures = 0;
      endfunction

      function int unsigned fill_level();
         return fill;
      endfunction

      function int unsigned outstanding();
         return pending_answers.size();
      endfunction

      function void report(string msg);
         failures++;
         if (failures <= 100) begin
            $display("%0t mismatch: %s", $time, msg);
         end
      endfunction

      // Insert before slot 'at'; the range check takes precedence over full.
      function logic [STATUS_W-1:0] place(int unsigned at, logic [DATA_W-1:0] val);
         int unsigned i;
         if (at > fill) begin
            return ST_RANGE;
         end
         if (fill >= CAPACITY_DEF) begin
            return ST_FULL;
         end
         for (i = fill; i > at; i--) begin
            slots[i] = slots[i-1];
         end
         slots[at] = val;
         fill++;
         return ST_DONE;
      endfunction

      function void note_request(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic [DATA_W-1:0] val);
         list_answer_type ans;
         int unsigned     i;
         ans.read_value = '0;
         ans.status     = ST_DONE;
         case (op)
            OP_READ: begin
               if (pos < fill) begin
                  ans.read_value = slots[pos];
               end else begin
                  ans.read_value = '1;
                  ans.status     = ST_RANGE;
               end
            end
            OP_FRONT:  ans.status = place(0, val);
            OP_APPEND: ans.status = place(fill, val);
            OP_INSERT: ans.status = place(pos, val);
            OP_DELETE: begin
               if (pos >= fill) begin
                  ans.status = ST_RANGE;
               end else begin
                  for (i = pos; i + 1 < fill; i++) begin
                     slots[i] = slots[i+1];
                  end
                  fill--;
               end
            end
            default: ;
         endcase
         ans.length = fill[LEN_W-1:0];
         pending_answers.push_back(ans);
      endfunction

      function void check_answer(logic [DATA_W-1:0] rd, logic [STATUS_W-1:0] st,
                                 logic [LEN_W-1:0] len);
         list_answer_type want;
         if (pending_answers.size() == 0) begin
            report($sformatf("unexpected item rd=%h st=%0d len=%0d", rd, st, len));
            return;
         end
         want = pending_answers.pop_front();
         if (rd !== want.read_value) begin
            report($sformatf("read_value got %h want %h", rd, want.read_value));
         end
         if (st !== want.status) begin
            report($sformatf("status got %0d want %0d", st, want.status));
         end
         if (len !== want.length) begin
            report($sformatf("length got %0d want %0d", len, want.length));
         end
      endfunction
   endclass

endpackage

/* bench/tb_top.sv */
// Top-level testbench for the indexed insert/delete list.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import iidl_pkg::*;
   import list_tracker_pkg::*;

   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 12;

   logic        clock;
   logic        reset;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned quiet_cycles;
   list_tracker book;

   iidl_req_if req_if ();
   iidl_rsp_if rsp_if ();

   indexed_insert_delete_list #(.CAPACITY(CAPACITY_DEF)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: ready toggles at random at the falling edge.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            book.note_request(req_if.opcode, req_if.position, req_if.value);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            book.check_answer(rsp_if.read_value, rsp_if.status, rsp_if.length);
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin : watchdog
      do @(posedge clock); while (quiet_cycles < IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [DATA_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid    = 1'b1;
      req_if.opcode   = op;
      req_if.position = pos;
      req_if.value    = val;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_empty();
      req_if.valid = 1'b0;
      while (book.outstanding() != 0) @(negedge clock);
   endtask

   task automatic directed_items();
      int k;
      send_item(OP_READ, 7'd0, 32'h1234_5678);     // read of an empty list
      send_item(OP_DELETE, 7'd0, 32'h0);           // delete from an empty list
      send_item(OP_INSERT, 7'd1, 32'h1111_1111);   // insert past the end
      send_item(OP_INSERT, 7'd0, 32'h7FFF_FFFF);   // position equal to length appends
      send_item(OP_FRONT, 7'h7F, 32'h8000_0000);
      send_item(OP_APPEND, 7'd0, 32'hFFFF_FFFF);
      send_item(OP_APPEND, 7'h7F, 32'h0);
      send_item(OP_INSERT, 7'd2, 32'h5A5A_5A5A);
      for (k = 0; k <= 4; k++) begin
         send_item(OP_READ, POS_W'(k), 32'hFFFF_FFFF);
      end
      send_item(OP_READ, 7'd5, 32'h0);
      send_item(OP_READ, 7'h7F, 32'h0);
      // unknown opcodes leave the list alone
      for (k = 1; k <= 3; k++) begin
         send_item(OP_DELETE + OPCODE_W'(k), 7'h7F, $urandom);
      end
      send_item(OP_DELETE, 7'h7F, 32'h0);
      send_item(OP_DELETE, 7'd4, 32'h0);           // last entry
      send_item(OP_DELETE, 7'd0, 32'h0);           // front entry
      send_item(OP_DELETE, 7'd1, 32'h0);
      send_item(OP_INSERT, 7'h40, 32'hDEAD_BEEF);
   endtask

   task automatic run_stretch(input int n, input int ins_pct, input int del_pct);
      int                  k;
      int                  r;
      int unsigned         span;
      logic [OPCODE_W-1:0] op;
      logic [POS_W-1:0]    pos;
      for (k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 3) begin
            op = OP_DELETE + OPCODE_W'($urandom_range(3, 1));
         end else if (r < 3 + ins_pct) begin
            r = $urandom_range(2);
            if (r == 0) begin
               op = OP_FRONT;
            end else if (r == 1) begin
               op = OP_APPEND;
            end else begin
               op = OP_INSERT;
            end
         end else if (r < 3 + ins_pct + del_pct) begin
            op = OP_DELETE;
         end else begin
            op = OP_READ;
         end
         span = book.fill_level();
         r = $urandom_range(9);
         if (r == 0) begin
            pos = POS_W'($urandom);
         end else if (r == 1) begin
            pos = POS_W'(span);
         end else begin
            pos = POS_W'($urandom_range(span));
         end
         send_item(op, pos, $urandom);
      end
   endtask

   initial begin
      int ph;
      book            = new();
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.opcode   = OP_READ;
      req_if.position = '0;
      req_if.value    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed_items();
      wait_empty();

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         // grow until full and beyond, churn, then drain down towards empty
         run_stretch(140, 70, 12);
         run_stretch(90, 35, 35);
         run_stretch(120, 12, 70);
         wait_empty();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (book.failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
